// File: hdl/bimodal_branch_predictor_unit_macros.svh
// assertion macros for the bimodal branch predictor
`ifndef BIMODAL_BRANCH_PREDICTOR_UNIT_MACROS_SVH
`define BIMODAL_BRANCH_PREDICTOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BBP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bbp assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define BBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bbp assertion failed");

`endif

// File: hdl/bbp_pkg.sv
// shared types and constants of the bimodal branch predictor
package bbp_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int MAX_CTR_BITS  = 8;
  localparam int CTR_W         = MAX_CTR_BITS;
  localparam int NSEL_W        = $clog2(MAX_CTR_BITS + 1);
  localparam int CFG_W         = 4;
  localparam int PC_W          = 32;
  localparam int TOTAL_W       = 40;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_CTR_BITS = REG_IDX_W'(0);
  localparam logic [CFG_W-1:0]     CTR_BITS_RST = CFG_W'(2);

  // outcome of one item as it leaves the table stage
  typedef struct packed {
    logic pred;
    logic miss;
  } bbp_res_t;

  // front status seen by the top level
  typedef struct packed {
    logic clearing;
    logic inflight;
  } front_stat_t;

endpackage

// File: hdl/bbp_front.sv
// table stage: counter lookup, prediction, counter update and reset clear
module bbp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      acc_i,
  input  logic [bbp_pkg::PC_W-1:0]  branch_pc_i,
  input  logic                      taken_i,
  input  logic [bbp_pkg::CFG_W-1:0] ctr_bits_i,
  output logic                      push_o,
  output bbp_pkg::bbp_res_t         res_o,
  output bbp_pkg::front_stat_t      stat_o
);
  import bbp_pkg::*;

  logic [CTR_W-1:0] mem [TABLE_ENTRIES];

  logic             clr_q, clr_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;
  logic             b_vld_q;
  logic [IDX_W-1:0] b_idx_q;
  logic             b_taken_q;
  logic [CTR_W-1:0] rd_q;
  logic             fwd_vld_q;
  logic [IDX_W-1:0] fwd_idx_q;
  logic [CTR_W-1:0] fwd_val_q;

  logic [IDX_W-1:0]  rd_idx;
  logic              we;
  logic [IDX_W-1:0]  wa;
  logic [CTR_W-1:0]  wd;
  logic [NSEL_W-1:0] n_use;
  logic [CTR_W-1:0]  cmax, thresh, raw, ctr, ctr_new;

  assign rd_idx = branch_pc_i[IDX_W+1:2];

  // clearing pass over the table after reset
  always_comb begin
    clr_d     = clr_q;
    clr_idx_d = clr_idx_q;
    if (clr_q) begin
      clr_idx_d = clr_idx_q + IDX_W'(1);
      if (clr_idx_q == {IDX_W{1'b1}}) begin
        clr_d = 1'b0;
      end
    end
  end

  // counter width in use
  always_comb begin
    if (ctr_bits_i == '0) begin
      n_use = NSEL_W'(1);
    end else if (int'(ctr_bits_i) > MAX_CTR_BITS) begin
      n_use = NSEL_W'(MAX_CTR_BITS);
    end else begin
      n_use = NSEL_W'(ctr_bits_i);
    end
    cmax   = ~({CTR_W{1'b1}} << n_use);
    thresh = CTR_W'(1) << (n_use - NSEL_W'(1));
  end

  // take the value written at the edge of the read when it hits the same entry
  assign raw = (fwd_vld_q && fwd_idx_q == b_idx_q) ? fwd_val_q : rd_q;

  always_comb begin
    ctr        = (raw > cmax) ? cmax : raw;
    res_o.pred = (ctr >= thresh);
    res_o.miss = res_o.pred ^ b_taken_q;
    ctr_new    = ctr;
    if (b_taken_q) begin
      if (ctr < cmax) begin
        ctr_new = ctr + CTR_W'(1);
      end
    end else if (ctr != '0) begin
      ctr_new = ctr - CTR_W'(1);
    end
  end

  assign we = clr_q || b_vld_q;
  assign wa = clr_q ? clr_idx_q : b_idx_q;
  assign wd = clr_q ? '0 : ctr_new;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (acc_i) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      b_idx_q   <= rd_idx;
      b_taken_q <= taken_i;
    end
    fwd_idx_q <= wa;
    fwd_val_q <= wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      b_vld_q   <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      clr_idx_q <= clr_idx_d;
      b_vld_q   <= acc_i;
      fwd_vld_q <= we;
    end
  end

  assign push_o          = b_vld_q;
  assign stat_o.clearing = clr_q;
  assign stat_o.inflight = b_vld_q;

endmodule

// File: hdl/bbp_queue.sv
// short fifo of item outcomes between the table stage and the totals stage
module bbp_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  bbp_pkg::bbp_res_t          data_i,
  input  logic                       pop_i,
  output bbp_pkg::bbp_res_t          data_o,
  output logic                       empty_o,
  output logic [bbp_pkg::QCNT_W-1:0] cnt_o
);
  import bbp_pkg::*;

  bbp_res_t          slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (int'(wr_q) == QDEPTH - 1) ? '0 : wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (int'(rd_q) == QDEPTH - 1) ? '0 : rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  assign data_o  = slot_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;

endmodule

// File: hdl/bbp_back.sv
// totals stage: running correct and miss totals and the result register
module bbp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  bbp_pkg::bbp_res_t           q_data_i,
  output logic                        q_pop_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic                        predicted_taken_o,
  output logic                        mispredicted_o,
  output logic [bbp_pkg::TOTAL_W-1:0] correct_total_o,
  output logic [bbp_pkg::TOTAL_W-1:0] miss_total_o
);
  import bbp_pkg::*;

  logic               out_vld_q;
  logic               pred_q, miss_q;
  logic [TOTAL_W-1:0] corr_q, corr_d, mtot_q, mtot_d;

  assign q_pop_o = !q_empty_i && (!out_vld_q || pop_i);

  // saturating bump of the total that this item counts toward
  always_comb begin
    corr_d = corr_q;
    mtot_d = mtot_q;
    if (q_data_i.miss) begin
      if (mtot_q != {TOTAL_W{1'b1}}) begin
        mtot_d = mtot_q + TOTAL_W'(1);
      end
    end else if (corr_q != {TOTAL_W{1'b1}}) begin
      corr_d = corr_q + TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      pred_q <= q_data_i.pred;
      miss_q <= q_data_i.miss;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      corr_q    <= '0;
      mtot_q    <= '0;
    end else begin
      if (q_pop_o) begin
        out_vld_q <= 1'b1;
        corr_q    <= corr_d;
        mtot_q    <= mtot_d;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign empty_o           = !out_vld_q;
  assign predicted_taken_o = pred_q;
  assign mispredicted_o    = miss_q;
  assign correct_total_o   = corr_q;
  assign miss_total_o      = mtot_q;

endmodule

// File: hdl/bimodal_branch_predictor_unit.sv
// top level of the bimodal branch predictor with its register port
//
// channel   direction  handshake               payload
// branch    in         push / full             branch_pc_i, taken_i
// result    out        empty / pop             predicted_taken_o, mispredicted_o,
//                                              correct_total_o, miss_total_o
// config    in         psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// one branch item per cycle while full is low; an item passes through the registered
// table read and the outcome queue before the result register loads it
// after reset the counter table is cleared one entry a cycle over all 1024 entries,
// with full held high; register writes are taken during that pass
// a stalled result side fills the four-entry outcome queue, then full rises
// while the result side is stalled, pushes keep going until the queue is full
module bimodal_branch_predictor_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // branch channel
  input  logic                          push,
  output logic                          full,
  input  logic [bbp_pkg::PC_W-1:0]      branch_pc_i,
  input  logic                          taken_i,
  // result channel
  output logic                          empty,
  input  logic                          pop,
  output logic                          predicted_taken_o,
  output logic                          mispredicted_o,
  output logic [bbp_pkg::TOTAL_W-1:0]   correct_total_o,
  output logic [bbp_pkg::TOTAL_W-1:0]   miss_total_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbp_pkg::PADDR_W-1:0]   paddr,
  input  logic [bbp_pkg::PDATA_W-1:0]   pwdata,
  output logic [bbp_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import bbp_pkg::*;

`include "bimodal_branch_predictor_unit_macros.svh"

  logic [CFG_W-1:0]  ctr_bits_q;
  logic              acc;
  logic              f_push;
  bbp_res_t          f_res;
  front_stat_t       f_stat;
  bbp_res_t          q_data;
  logic              q_empty;
  logic              q_pop;
  logic [QCNT_W-1:0] q_cnt;
  logic              reg_hit;

  // register port: single register, no wait states
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_CTR_BITS);
  assign prdata  = reg_hit ? PDATA_W'(ctr_bits_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_bits_q <= CTR_BITS_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      ctr_bits_q <= pwdata[CFG_W-1:0];
    end
  end

  // hold off pushes while clearing, or when the queue cannot take the
  // outcomes already on their way plus this one
  assign full = f_stat.clearing ||
                ((QCNT_W+1)'(q_cnt) + (QCNT_W+1)'(f_stat.inflight) >= (QCNT_W+1)'(QDEPTH));
  assign acc  = push && !full;

  bbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .branch_pc_i (branch_pc_i),
    .taken_i     (taken_i),
    .ctr_bits_i  (ctr_bits_q),
    .push_o      (f_push),
    .res_o       (f_res),
    .stat_o      (f_stat)
  );

  bbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_res),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty),
    .cnt_o   (q_cnt)
  );

  bbp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_data_i          (q_data),
    .q_pop_o           (q_pop),
    .pop_i             (pop),
    .empty_o           (empty),
    .predicted_taken_o (predicted_taken_o),
    .mispredicted_o    (mispredicted_o),
    .correct_total_o   (correct_total_o),
    .miss_total_o      (miss_total_o)
  );

  // an outcome never lands in a full queue unless one leaves in the same cycle
  `BBP_ASSERT_IMPL(a_queue_room, f_push && !q_pop, int'(q_cnt) < QDEPTH)
  // an outcome that is not drained right away raises the queue count by one
  `BBP_ASSERT_NEXT(a_queue_grow, f_push && !q_pop, q_cnt == $past(q_cnt) + QCNT_W'(1))
  // no item enters the table stage during the clearing pass
  `BBP_ASSERT_NEXT(a_no_item_clr, f_stat.clearing, !f_stat.inflight)

endmodule

// File: sim/bimodal_branch_predictor_unit_test.sv
// testbench for the bimodal branch predictor unit: directed and random branch streams
`timescale 1ns / 100ps

module bimodal_branch_predictor_unit_test;
  import bbp_pkg::*;

  localparam int RST_CYCLES   = 12;
  // extra wait after the last expected result has been popped
  localparam int DRAIN_CYCLES = 6;
  localparam logic [TOTAL_W-1:0] TOTAL_FULL    = {TOTAL_W{1'b1}};
  localparam logic [PADDR_W-1:0] ADDR_CTR_BITS = {REG_CTR_BITS, 2'b00};
  // the only other word address decodes to no register
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = {~REG_CTR_BITS, 2'b00};

  // what one branch item should produce
  typedef struct {
    bbp_res_t           outcome;
    logic [TOTAL_W-1:0] correct_total;
    logic [TOTAL_W-1:0] miss_total;
  } branch_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [PC_W-1:0]      branch_pc_i;
  logic                 taken_i;
  logic                 empty;
  logic                 pop;
  logic                 predicted_taken_o;
  logic                 mispredicted_o;
  logic [TOTAL_W-1:0]   correct_total_o;
  logic [TOTAL_W-1:0]   miss_total_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // predictor state kept alongside the block
  logic [CTR_W-1:0]     ctr_model [TABLE_ENTRIES];
  logic [TOTAL_W-1:0]   correct_model;
  logic [TOTAL_W-1:0]   miss_model;
  logic [CFG_W-1:0]     width_model;

  branch_result_t       outcome_q [$];
  int                   fail_cnt = 0;
  // random gaps on the branch side and random stalls on the result side
  bit                   idle_on = 1'b0;

  bimodal_branch_predictor_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .branch_pc_i       (branch_pc_i),
    .taken_i           (taken_i),
    .empty             (empty),
    .pop               (pop),
    .predicted_taken_o (predicted_taken_o),
    .mispredicted_o    (mispredicted_o),
    .correct_total_o   (correct_total_o),
    .miss_total_o      (miss_total_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop in case a handshake never completes
  initial begin
    #2_000_000;
    $display("bimodal_branch_predictor_unit_test: errors");
    $finish;
  end

  // work out the outcome of one resolved branch and move the model counter
  function automatic void predict_outcome(logic [PC_W-1:0] pc, logic tk);
    int unsigned      n;
    int unsigned      cmax;
    int unsigned      c;
    logic [IDX_W-1:0] idx;
    branch_result_t   r;
    // width zero acts as one, anything past the maximum acts as the maximum
    n = 32'(width_model);
    if (n == 0) n = 1;
    if (n > MAX_CTR_BITS) n = MAX_CTR_BITS;
    cmax = (1 << n) - 1;
    idx  = pc[IDX_W+1:2];
    // a counter left over from a wider setting reads as the current maximum
    c = 32'(ctr_model[idx]);
    if (c > cmax) c = cmax;
    r.outcome.pred = (c >= (1 << (n - 1)));
    r.outcome.miss = (r.outcome.pred != tk);
    // totals stick at their top value
    if (r.outcome.miss) begin
      if (miss_model != TOTAL_FULL) miss_model++;
    end else begin
      if (correct_model != TOTAL_FULL) correct_model++;
    end
    if (tk && c < cmax) c++;
    else if (!tk && c > 0) c--;
    ctr_model[idx]  = CTR_W'(c);
    r.correct_total = correct_model;
    r.miss_total    = miss_model;
    outcome_q.push_back(r);
  endfunction

  // offer one branch item, hold it until taken; push stays high afterwards
  task automatic send_branch(logic [PC_W-1:0] pc, logic tk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    push        <= 1'b1;
    branch_pc_i <= pc;
    taken_i     <= tk;
    do @(posedge clk_i); while (full);
    predict_outcome(pc, tk);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    push <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write, setup then access, then back to idle
  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    // writes to an unmapped address leave the width alone
    if (addr[PADDR_W-1:2] == REG_CTR_BITS) width_model = data[CFG_W-1:0];
    @(posedge clk_i);
  endtask

  // read the counter width back and compare
  task automatic check_width_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_CTR_BITS;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== PDATA_W'(width_model)) begin
      $error("counter_bits: expected %0h, got %0h", PDATA_W'(width_model), prdata);
      fail_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // change the width between phases, with junk above the field half the time
  task automatic set_width(logic [CFG_W-1:0] w);
    logic [PDATA_W-1:0] data;
    drain_results();
    data = $urandom_range(0, 1) ? {$urandom()} : '0;
    data[CFG_W-1:0] = w;
    write_reg(ADDR_CTR_BITS, data);
    check_width_reg();
  endtask

  // reset value, and a write to the unmapped address that must not land
  task automatic test_register_access();
    check_width_reg();
    write_reg(ADDR_UNMAPPED, 32'hFFFF_FFF7);
    check_width_reg();
  endtask

  // pc extremes, index aliasing, and the odd width settings
  task automatic test_directed_branches();
    logic [PC_W-1:0] corner_pc [9] = '{32'h0000_0000, 32'h0000_0003, 32'h0000_1000,
                                       32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h0000_0FFC,
                                       32'hFFFF_F000, 32'hAAAA_AAAA, 32'h5555_5555};
    logic            corner_tk [9] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    logic            one_bit_tk [4] = '{1'b1, 1'b1, 1'b0, 1'b0};
    // default two-bit counters; several pcs alias onto entries 0 and 1023
    foreach (corner_pc[i]) send_branch(corner_pc[i], corner_tk[i]);
    // width zero behaves as one bit
    set_width(4'd0);
    foreach (one_bit_tk[i]) send_branch(32'h0000_0040, one_bit_tk[i]);
    // all ones in the data word, width too large clamps to the maximum
    drain_results();
    write_reg(ADDR_CTR_BITS, 32'hFFFF_FFFF);
    check_width_reg();
    send_branch(32'h0000_0080, 1'b0);
    send_branch(32'h0000_0080, 1'b1);
    // saturate a three-bit counter, then narrow the width under it
    set_width(4'd3);
    repeat (7) send_branch(32'h0000_0100, 1'b1);
    set_width(4'd1);
    send_branch(32'h0000_0100, 1'b0);
    send_branch(32'h0000_0100, 1'b1);
  endtask

  // one phase of biased random traffic at a given width
  task automatic run_phase(logic [CFG_W-1:0] w, int items, int pool_size, bit pause_mid);
    logic [PC_W-1:0] hot_pc [8];
    int              bias [8];
    int              bias_set [3] = '{3, 50, 97};
    int              slot;
    logic [PC_W-1:0] pc;
    set_width(w);
    foreach (hot_pc[i]) begin
      hot_pc[i] = $urandom();
      bias[i]   = bias_set[$urandom_range(0, 2)];
    end
    // the first hot branch is strongly taken so wide counters reach the top
    bias[0] = 97;
    for (int k = 0; k < items; k++) begin
      if (pause_mid && k == items / 2) drain_results();
      slot = $urandom_range(0, pool_size - 1);
      if ($urandom_range(0, 4) == 0) begin
        // cold branch anywhere in the address space
        send_branch($urandom(), 1'($urandom_range(0, 1)));
      end else begin
        pc = hot_pc[slot];
        // same entry reached from a different address now and then
        if ($urandom_range(0, 3) == 0) begin
          pc[1:0]       = 2'($urandom_range(0, 3));
          pc[PC_W-1:12] = (PC_W-12)'($urandom());
        end
        send_branch(pc, $urandom_range(0, 99) < bias[slot]);
      end
    end
  endtask

  // sequence of widths, mixing wide and narrow phases
  task automatic test_random_phases();
    logic [CFG_W-1:0] widths [10] = '{4'd2, 4'd1, 4'd8, 4'd0, 4'd15,
                                      4'd3, 4'd9, 4'd5, 4'd8, 4'd2};
    int               counts [10] = '{150, 150, 300, 150, 150, 150, 150, 150, 150, 150};
    int               pools  [10] = '{8, 4, 1, 4, 2, 8, 2, 6, 1, 8};
    foreach (widths[i]) begin
      // random gaps and stalls off in the fourth phase and in the last two
      idle_on = !(i == 3 || i >= 8);
      run_phase(widths[i], counts[i], pools[i], i == 4);
    end
  endtask

  // result side: compare every popped item with the oldest expectation
  initial begin : result_checker
    branch_result_t exp_r;
    int             stall_left;
    stall_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (outcome_q.size() == 0) begin
          $error("result item with nothing expected");
          fail_cnt++;
        end else begin
          exp_r = outcome_q.pop_front();
          if (predicted_taken_o !== exp_r.outcome.pred) begin
            $error("predicted_taken: expected %0b, got %0b",
                   exp_r.outcome.pred, predicted_taken_o);
            fail_cnt++;
          end
          if (mispredicted_o !== exp_r.outcome.miss) begin
            $error("mispredicted: expected %0b, got %0b",
                   exp_r.outcome.miss, mispredicted_o);
            fail_cnt++;
          end
          if (correct_total_o !== exp_r.correct_total) begin
            $error("correct_total: expected %0d, got %0d",
                   exp_r.correct_total, correct_total_o);
            fail_cnt++;
          end
          if (miss_total_o !== exp_r.miss_total) begin
            $error("miss_total: expected %0d, got %0d", exp_r.miss_total, miss_total_o);
            fail_cnt++;
          end
        end
      end
      // random stall bursts on the result side while idle_on is set
      if (!rst_ni) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 4);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // branch side and register port
  initial begin : stimulus
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    branch_pc_i <= '0;
    taken_i     <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    foreach (ctr_model[i]) ctr_model[i] = '0;
    correct_model = '0;
    miss_model    = '0;
    width_model   = CTR_BITS_RST;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // the table clearing pass runs behind the register test, full holds items off
    test_register_access();
    idle_on = 1'b1;
    test_directed_branches();
    test_random_phases();
    drain_results();
    if (fail_cnt == 0) begin
      $display("bimodal_branch_predictor_unit_test: clean");
    end else begin
      $display("bimodal_branch_predictor_unit_test: errors");
    end
    $finish;
  end

endmodule
